// File: rtl/lphm_pkg.sv
// Shared types, constants and codes for the linear probing hash map.
package lphm_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_WIDTH = 64;
  localparam int VALUE_W   = 64;
  localparam int HASH_W    = 32;
  localparam int SLOT_W    = 10;
  localparam int MAX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int HBIT_W    = $clog2(HASH_W);
  localparam bit CAP_POW2  = ((CAPACITY & (CAPACITY - 1)) == 0);

  // Configuration port.
  localparam int APB_DW = 32;
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_MAX_ENTRIES = '0;
  localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = MAX_W'(768);

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_PUT    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_HIT      = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_MISS     = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_HASH,
    FSM_READ,
    FSM_PROBE
  } fsm_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [63:0]         key;
    logic [HASH_W-1:0]   key_hash;
    logic [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [VALUE_W-1:0]  value_out;
    logic [SLOT_W-1:0]   slot;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_WIDTH-1:0] key;
    logic [VALUE_W-1:0]   value;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

endpackage

// File: rtl/lphm_store.sv
// Slot memory: one word per slot holding valid bit, key and value.
module lphm_store (
  input  logic                    clk,
  input  lphm_pkg::mem_wr_t       wr,
  input  logic [lphm_pkg::IDX_W-1:0] rd_addr,
  output lphm_pkg::entry_t        rd_data
);
  import lphm_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/lphm_probe.sv
// Probe sequencer: start slot reduction, slot clearing and one probe per cycle.
module lphm_probe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  lphm_pkg::in_item_t         in_item,
  input  logic [lphm_pkg::MAX_W-1:0] max_entries,
  output logic                       busy,
  output logic                       out_valid,
  output lphm_pkg::out_item_t        out_item,
  output lphm_pkg::mem_wr_t          mem_wr,
  output logic [lphm_pkg::IDX_W-1:0] rd_addr,
  input  lphm_pkg::entry_t           rd_data
);
  import lphm_pkg::*;

  fsm_e                 state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [HASH_W-1:0]    hsh_r, hsh_nxt;
  logic [HBIT_W-1:0]    bit_r, bit_nxt;
  cmd_e                 cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]     entry_cnt_r, entry_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic [IDX_W-1:0] idx_inc;
  logic             hit;
  logic             room;
  logic             last_probe;
  logic [IDX_W:0]   mod_t;
  logic             mod_ge;
  logic [IDX_W-1:0] mod_rem;

  assign idx_inc    = (idx_r == IDX_W'(CAPACITY - 1)) ? '0 : idx_r + 1'b1;
  assign hit        = rd_data.valid && (rd_data.key == key_r);
  assign room       = entry_cnt_r < {1'b0, max_entries};
  assign last_probe = (cnt_r == IDX_W'(CAPACITY - 1));

  // Restoring reduction of the hash, one hash bit per cycle, used when the
  // capacity is not a power of two.
  assign mod_t   = {idx_r, hsh_r[HASH_W-1]};
  assign mod_ge  = (mod_t >= (IDX_W+1)'(CAPACITY));
  assign mod_rem = mod_ge ? IDX_W'(mod_t - (IDX_W+1)'(CAPACITY)) : IDX_W'(mod_t);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_CLEAR;
      idx_r       <= '0;
      entry_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    hsh_r      <= hsh_nxt;
    bit_r      <= bit_nxt;
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    hsh_nxt       = hsh_r;
    bit_nxt       = bit_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    entry_cnt_nxt = entry_cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_wr        = '0;
    rd_addr       = idx_r;

    unique case (state_r)
      FSM_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = idx_r;
        mem_wr.data = '0;
        if (idx_r == IDX_W'(CAPACITY - 1)) begin
          idx_nxt   = '0;
          state_nxt = FSM_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      FSM_IDLE: begin
        if (start) begin
          cmd_nxt = in_item.cmd;
          key_nxt = in_item.key[KEY_WIDTH-1:0];
          val_nxt = in_item.value;
          cnt_nxt = '0;
          hsh_nxt = in_item.key_hash;
          bit_nxt = '0;
          if (CAP_POW2) begin
            idx_nxt   = IDX_W'(in_item.key_hash);
            state_nxt = FSM_READ;
          end else begin
            idx_nxt   = '0;
            state_nxt = FSM_HASH;
          end
        end
      end
      FSM_HASH: begin
        idx_nxt = mod_rem;
        hsh_nxt = hsh_r << 1;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == HBIT_W'(HASH_W - 1)) begin
          state_nxt = FSM_READ;
        end
      end
      FSM_READ: begin
        state_nxt = FSM_PROBE;
      end
      FSM_PROBE: begin
        // The next slot is read ahead so that a probe completes every cycle.
        rd_addr = idx_inc;
        out_item_nxt.value_out = '0;
        out_item_nxt.slot      = '0;
        if (!rd_data.valid) begin
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
          out_item_nxt.status = STAT_MISS;
          if (cmd_r == CMD_PUT) begin
            if (room) begin
              mem_wr.en   = 1'b1;
              mem_wr.addr = idx_r;
              mem_wr.data = '{valid: 1'b1, key: key_r, value: val_r};
              entry_cnt_nxt = entry_cnt_r + 1'b1;
              out_item_nxt.status = STAT_INSERTED;
              out_item_nxt.slot   = SLOT_W'(idx_r);
            end else begin
              out_item_nxt.status = STAT_FULL;
            end
          end
        end else if (hit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
          out_item_nxt.status = STAT_HIT;
          out_item_nxt.slot   = SLOT_W'(idx_r);
          if (cmd_r == CMD_PUT) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = idx_r;
            mem_wr.data = '{valid: 1'b1, key: key_r, value: val_r};
          end else begin
            out_item_nxt.value_out = rd_data.value;
          end
        end else if (last_probe) begin
          // Every slot is occupied by another key.
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
          out_item_nxt.status = (cmd_r == CMD_PUT) ? STAT_FULL : STAT_MISS;
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/linear_probe_hash_map_unit.sv
// Top level of the linear probing hash map with its configuration register.
//
// An operation is taken when start is high while busy is low. From reset the
// block first clears the valid bit of every slot, one slot per cycle, and is
// busy while it does so. For an operation, the READ state reads the start
// slot, then the probe sequencer compares one slot per cycle against the
// single read port of the slot memory, and the result transfer appears on
// out_item with out_valid for exactly one cycle, in the cycle in which busy
// falls. The receiver cannot stall and must take each result in that cycle.
// With a capacity that is not a power of two, the start slot is reduced one
// hash bit per cycle.
module linear_probe_hash_map_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  lphm_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output lphm_pkg::out_item_t               out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lphm_pkg::PADDR_W-1:0]      paddr,
  input  logic [lphm_pkg::APB_DW-1:0]       pwdata,
  output logic [lphm_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import lphm_pkg::*;

  logic [MAX_W-1:0] max_entries_r;
  logic             cfg_wr;
  logic             reg_hit;
  mem_wr_t          mem_wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_MAX_ENTRIES);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? APB_DW'(max_entries_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
    end else if (cfg_wr) begin
      max_entries_r <= pwdata[MAX_W-1:0];
    end
  end

  lphm_probe u_probe (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_item     (in_item),
    .max_entries (max_entries_r),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .mem_wr      (mem_wr),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  lphm_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/lphm_checker.sv
// Port-level checks for the hash map top level and their bind.
module lphm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input lphm_pkg::out_item_t          out_item
);
  import lphm_pkg::*;

  // An accepted operation keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted operation did not make the block busy");

  // Every operation needs at least a read and a probe, so results never
  // come back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result transfers in consecutive cycles");

  // Only a successful lookup or update may return a nonzero value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != STAT_HIT |-> out_item.value_out == '0)
    else $error("nonzero value with a status other than found");

  // A miss or a refused put reports slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == STAT_MISS || out_item.status == STAT_FULL)
    |-> out_item.slot == '0)
    else $error("nonzero slot on a miss or refused put");

endmodule

bind linear_probe_hash_map_unit lphm_checker u_lphm_checker (.*);

// File: dv/linear_probe_hash_map_unit_tb.sv
// Self-checking testbench for the linear probing hash map unit.
module linear_probe_hash_map_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lphm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned POOL_SIZE = 40;
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_MAX_ENTRIES, 2'b00};
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_WIDTH);

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // Shadow copy of the table, its occupancy and the entry limit.
  bit tbl_valid [CAPACITY];
  logic [63:0] tbl_key [CAPACITY];
  logic [63:0] tbl_value [CAPACITY];
  int unsigned tbl_count = 0;
  int unsigned tbl_limit = MAX_ENTRIES_RST;

  out_item_t pending_results [$];
  out_item_t want;
  logic [63:0] pool_key [POOL_SIZE];
  logic [SLOT_W-1:0] pool_slot [POOL_SIZE];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned limit_writes = 0;
  int unsigned longest_probe = 0;
  int unsigned stat_tally [4];
  int unsigned cycles = 0;

  linear_probe_hash_map_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("linear_probe_hash_map_unit_tb failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Walks the shadow table exactly as the block should and updates it.
  function automatic out_item_t apply_to_table(input in_item_t op);
    out_item_t res;
    logic [63:0] k;
    int unsigned idx;
    int unsigned n;
    k = op.key & KEY_MASK;
    idx = op.key_hash % CAPACITY;
    res.status = STAT_MISS;
    res.value_out = '0;
    res.slot = '0;
    for (n = 0; n < CAPACITY; n++) begin
      if (!tbl_valid[idx]) begin
        if (op.cmd == CMD_PUT) begin
          if (tbl_count < tbl_limit) begin
            tbl_valid[idx] = 1'b1;
            tbl_key[idx] = k;
            tbl_value[idx] = op.value;
            tbl_count++;
            res.status = STAT_INSERTED;
            res.slot = SLOT_W'(idx);
          end else begin
            res.status = STAT_FULL;
          end
        end
        break;
      end
      if (tbl_key[idx] == k) begin
        res.status = STAT_HIT;
        res.slot = SLOT_W'(idx);
        if (op.cmd == CMD_PUT) tbl_value[idx] = op.value;
        else res.value_out = tbl_value[idx];
        break;
      end
      idx = (idx + 1) % CAPACITY;
    end
    // A probe that wrapped all the way round finds no room for a put.
    if (n == CAPACITY && op.cmd == CMD_PUT) res.status = STAT_FULL;
    if (n + 1 > longest_probe) longest_probe = (n < CAPACITY) ? n + 1 : n;
    stat_tally[res.status]++;
    return res;
  endfunction

  function automatic in_item_t op_of(input cmd_e c, input logic [63:0] k,
                                     input logic [31:0] h, input logic [63:0] v);
    in_item_t it;
    it.cmd = c;
    it.key = k;
    it.key_hash = h;
    it.value = v;
    return it;
  endfunction

  // Mostly keys from a colliding pool with their own start slot; the rest is
  // fresh keys and pool keys under a foreign hash.
  function automatic in_item_t make_random_op(input int unsigned put_pct);
    in_item_t it;
    int unsigned pick;
    int unsigned roll;
    logic [31:0] h;
    pick = $urandom_range(0, POOL_SIZE - 1);
    roll = $urandom_range(0, 99);
    h = $urandom;
    it.cmd = ($urandom_range(0, 99) < put_pct) ? CMD_PUT : CMD_LOOKUP;
    it.value = {$urandom, $urandom};
    it.key = pool_key[pick];
    if (roll < 70) h[SLOT_W-1:0] = pool_slot[pick];
    else if (roll < 85) it.key = {$urandom, $urandom};
    it.key_hash = h;
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: status %0d slot %0d",
                                out_item.status, out_item.slot));
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d",
                                  out_item.status, want.status));
        if (out_item.value_out !== want.value_out)
          flag_mismatch($sformatf("value_out %h, expected %h",
                                  out_item.value_out, want.value_out));
        if (out_item.slot !== want.slot)
          flag_mismatch($sformatf("slot %0d, expected %0d", out_item.slot, want.slot));
      end
    end
  end

  // Called at a rising edge; leaves start high so the next item can follow.
  task automatic send_op(input in_item_t op);
    in_item <= op;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_to_table(op));
    items_sent++;
  endtask

  task automatic idle_gap(input bit gaps_on);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic check_limit_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== APB_DW'(tbl_limit))
      flag_mismatch($sformatf("max_entries reads %0d, expected %0d", prdata, tbl_limit));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random; only the low field of the register counts.
  task automatic set_limit(input int unsigned lim);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[MAX_W-1:0] = lim[MAX_W-1:0];
    wait_drained();
    check_limit_readback();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tbl_limit = word[MAX_W-1:0];
    limit_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    check_limit_readback();
  endtask

  task automatic test_register_access();
    set_limit(1);
    set_limit(1023);
  endtask

  // Collisions at the top slot wrap to slot 0; extremes of every field.
  task automatic test_directed_ops();
    send_op(op_of(CMD_LOOKUP, 64'd0, 32'd0, 64'd0));
    send_op(op_of(CMD_PUT, '1, '1, 64'd0));
    send_op(op_of(CMD_PUT, 64'd0, '1, '1));
    send_op(op_of(CMD_LOOKUP, 64'd0, 32'h0000_03FF, 64'd0));
    send_op(op_of(CMD_LOOKUP, '1, '1, 64'd0));
    send_op(op_of(CMD_PUT, '1, '1, 64'hA5A5_5A5A_F00F_0FF0));
    send_op(op_of(CMD_LOOKUP, '1, 32'h0000_03FF, '1));
    send_op(op_of(CMD_LOOKUP, 64'd1, '1, 64'd0));
    send_op(op_of(CMD_PUT, 64'd1, 32'd0, 64'd1));
    send_op(op_of(CMD_LOOKUP, 64'h8000_0000_0000_0000, 32'h0000_0400, 64'd0));
    send_op(op_of(CMD_PUT, 64'h8000_0000_0000_0000, 32'hFFFF_FC00, 64'h8000_0000_0000_0001));
    send_op(op_of(CMD_LOOKUP, 64'd1, 32'h1234_5401, 64'd0));
    send_op(op_of(CMD_LOOKUP, 64'd0, 32'd0, '1));
    send_op(op_of(CMD_PUT, 64'd0, 32'd0, 64'd0));
    send_op(op_of(CMD_LOOKUP, 64'd0, 32'h8000_0000, 64'd0));
  endtask

  // Zero limit still updates, refused puts leave the table alone.
  task automatic test_limit_corners();
    set_limit(0);
    send_op(op_of(CMD_PUT, 64'd1, 32'd1, 64'h0123_4567_89AB_CDEF));
    send_op(op_of(CMD_PUT, 64'h5555_5555_5555_5555, 32'd5, 64'd7));
    send_op(op_of(CMD_LOOKUP, 64'h5555_5555_5555_5555, 32'd5, 64'd0));
    set_limit(1);
    send_op(op_of(CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 32'd9, 64'd3));
    set_limit(tbl_count + 1);
    send_op(op_of(CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 32'd9, 64'd3));
    send_op(op_of(CMD_PUT, 64'h3333_3333_3333_3333, 32'd9, 64'd4));
    send_op(op_of(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'd9, 64'd0));
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned put_pct,
                                     input bit gaps_on);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (gaps_on && i == n_items / 2) wait_drained();
      idle_gap(gaps_on);
      send_op(make_random_op(put_pct));
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = {$urandom, $urandom};
      case ($urandom_range(0, 2))
        0: pool_slot[i] = SLOT_W'(CAPACITY - 4 + $urandom_range(0, 3));
        1: pool_slot[i] = SLOT_W'($urandom_range(0, 3));
        default: pool_slot[i] = SLOT_W'($urandom);
      endcase
    end
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its valid bits before it takes any work.
    do @(posedge clk); while (busy !== 1'b0);

    test_register_access();
    test_directed_ops();
    test_limit_corners();
    set_limit(1023);
    test_random_traffic(140, 55, 1'b1);
    set_limit((tbl_count + 6 > 1023) ? 1023 : tbl_count + 6);
    test_random_traffic(100, 75, 1'b1);
    set_limit(MAX_ENTRIES_RST);
    test_random_traffic(100, 40, 1'b1);
    set_limit(1023);
    test_random_traffic(60, 50, 1'b0);

    wait_drained();
    repeat (CAPACITY + 8) @(posedge clk);
    $display("Sent %0d operations under %0d limit writes: %0d hits, %0d inserts, %0d misses,",
             items_sent, limit_writes, stat_tally[STAT_HIT], stat_tally[STAT_INSERTED],
             stat_tally[STAT_MISS]);
    $display("%0d refused puts; %0d entries stored, longest probe %0d slots, %0d results.",
             stat_tally[STAT_FULL], tbl_count, longest_probe, results_seen);
    if (mismatches == 0) begin
      $display("linear_probe_hash_map_unit_tb passed");
    end else begin
      $display("linear_probe_hash_map_unit_tb failed");
    end
    $finish;
  end

endmodule
